[sv/websocket_frame_deframer_unit_macros.svh]
// Assertion helpers shared by the checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_MACROS_SVH

// Clocked check, muted while reset is high.
`define WSDF_CHECK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked check that also runs across reset.
`define WSDF_CHECK_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

[sv/wsdf_pkg.sv]
`timescale 1ns / 1ps
package wsdf_pkg;

  localparam logic [2:0] KIND_DATA       = 3'd0;
  localparam logic [2:0] KIND_PING       = 3'd1;
  localparam logic [2:0] KIND_PING_EMPTY = 3'd2;
  localparam logic [2:0] KIND_STOP       = 3'd3;
  localparam logic [2:0] KIND_MSG_EMPTY  = 3'd4;

  localparam logic [2:0] STOP_CLOSE       = 3'd0;
  localparam logic [2:0] STOP_NO_MASK     = 3'd1;
  localparam logic [2:0] STOP_TOO_LARGE   = 3'd2;
  localparam logic [2:0] STOP_DATA_OPEN   = 3'd3;
  localparam logic [2:0] STOP_ORPHAN_CONT = 3'd4;
  localparam logic [2:0] STOP_EMPTY_MSG   = 3'd5;
  localparam logic [2:0] STOP_BAD_OPCODE  = 3'd6;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;

  // Classified result: payload bytes still carry their mask byte.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] raw;
    logic [7:0] key;
    logic       text;
    logic       frame_last;
    logic       message_last;
    logic [2:0] code;
  } entry_t;

endpackage

[sv/wsdf_front.sv]
`timescale 1ns / 1ps
module wsdf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_write,
  input  logic [15:0]         cfg_data,
  output logic                emit,
  output wsdf_pkg::entry_t    entry
);

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXT16   = 3'd2;
  localparam logic [2:0] PH_EXT64   = 3'd3;
  localparam logic [2:0] PH_MASK    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  logic [2:0]  phase, phase_next;
  logic        fin, fin_next;
  logic [3:0]  opcode, opcode_next;
  logic [63:0] len_acc, len_acc_next;
  logic [2:0]  hcount, hcount_next;
  logic [31:0] mask_key, mask_key_next;
  logic [15:0] pos, pos_next;
  logic        msg_open, msg_open_next;
  logic        msg_text, msg_text_next;
  logic        stopped, stopped_next;
  logic [15:0] max_payload;

  logic [63:0] len_shift;
  logic [63:0] len_cand;
  logic        too_large;
  logic        ext_done;
  logic        len_zero;
  logic [16:0] pos_inc;
  logic        last;
  logic [7:0]  key_sel;

  always_comb begin
    len_shift = {len_acc[55:0], rx_byte};
    len_cand  = (phase == PH_HDR1) ? {57'd0, rx_byte[6:0]} : len_shift;
    too_large = (len_cand[63:16] != 48'd0) || (len_cand[15:0] > max_payload);
    ext_done  = (phase == PH_EXT16) ? (hcount == 3'd1) : (hcount == 3'd7);
    len_zero  = (len_acc == 64'd0);
    pos_inc   = {1'b0, pos} + 17'd1;
    // Length was checked against a 16-bit limit, so its low bits suffice.
    last      = pos_inc >= {1'b0, len_acc[15:0]};
    case (pos[1:0])
      2'd0:    key_sel = mask_key[31:24];
      2'd1:    key_sel = mask_key[23:16];
      2'd2:    key_sel = mask_key[15:8];
      default: key_sel = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next    = phase;
    fin_next      = fin;
    opcode_next   = opcode;
    len_acc_next  = len_acc;
    hcount_next   = hcount;
    mask_key_next = mask_key;
    pos_next      = pos;
    msg_open_next = msg_open;
    msg_text_next = msg_text;
    stopped_next  = stopped;
    emit          = 1'b0;
    entry         = '0;
    if (accept && !stopped) begin
      case (phase)
        PH_HDR0: begin
          fin_next    = rx_byte[7];
          opcode_next = rx_byte[3:0];
          phase_next  = PH_HDR1;
        end
        PH_HDR1: begin
          if (!rx_byte[7]) begin
            stopped_next = 1'b1;
            emit         = 1'b1;
            entry.kind   = wsdf_pkg::KIND_STOP;
            entry.code   = wsdf_pkg::STOP_NO_MASK;
          end else begin
            hcount_next   = 3'd0;
            len_acc_next  = 64'd0;
            mask_key_next = 32'd0;
            if (rx_byte[6:0] == 7'd126) begin
              phase_next = PH_EXT16;
            end else if (rx_byte[6:0] == 7'd127) begin
              phase_next = PH_EXT64;
            end else begin
              len_acc_next = len_cand;
              if (too_large) begin
                stopped_next = 1'b1;
                emit         = 1'b1;
                entry.kind   = wsdf_pkg::KIND_STOP;
                entry.code   = wsdf_pkg::STOP_TOO_LARGE;
              end else begin
                phase_next = PH_MASK;
              end
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          len_acc_next = len_shift;
          if (!ext_done) begin
            hcount_next = hcount + 3'd1;
          end else begin
            hcount_next = 3'd0;
            if (too_large) begin
              stopped_next = 1'b1;
              emit         = 1'b1;
              entry.kind   = wsdf_pkg::KIND_STOP;
              entry.code   = wsdf_pkg::STOP_TOO_LARGE;
            end else begin
              phase_next = PH_MASK;
            end
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], rx_byte};
          if (hcount < 3'd3) begin
            hcount_next = hcount + 3'd1;
          end else begin
            // Header complete: decide on the opcode.
            hcount_next = 3'd0;
            pos_next    = 16'd0;
            phase_next  = len_zero ? PH_HDR0 : PH_PAYLOAD;
            case (opcode)
              wsdf_pkg::OP_CLOSE: begin
                stopped_next = 1'b1;
                emit         = 1'b1;
                entry.kind   = wsdf_pkg::KIND_STOP;
                entry.code   = wsdf_pkg::STOP_CLOSE;
              end
              wsdf_pkg::OP_PING: begin
                if (len_zero) begin
                  emit             = 1'b1;
                  entry.kind       = wsdf_pkg::KIND_PING_EMPTY;
                  entry.frame_last = 1'b1;
                end
              end
              wsdf_pkg::OP_PONG: begin
                emit = 1'b0;
              end
              wsdf_pkg::OP_TEXT, wsdf_pkg::OP_BINARY: begin
                if (msg_open) begin
                  stopped_next = 1'b1;
                  emit         = 1'b1;
                  entry.kind   = wsdf_pkg::KIND_STOP;
                  entry.code   = wsdf_pkg::STOP_DATA_OPEN;
                end else begin
                  msg_text_next = (opcode == wsdf_pkg::OP_TEXT);
                  if (len_zero) begin
                    if (fin) begin
                      stopped_next = 1'b1;
                      emit         = 1'b1;
                      entry.kind   = wsdf_pkg::KIND_STOP;
                      entry.code   = wsdf_pkg::STOP_EMPTY_MSG;
                    end
                  end else begin
                    msg_open_next = 1'b1;
                  end
                end
              end
              wsdf_pkg::OP_CONT: begin
                if (!msg_open) begin
                  stopped_next = 1'b1;
                  emit         = 1'b1;
                  entry.kind   = wsdf_pkg::KIND_STOP;
                  entry.code   = wsdf_pkg::STOP_ORPHAN_CONT;
                end else if (len_zero && fin) begin
                  msg_open_next      = 1'b0;
                  emit               = 1'b1;
                  entry.kind         = wsdf_pkg::KIND_MSG_EMPTY;
                  entry.text         = msg_text;
                  entry.frame_last   = 1'b1;
                  entry.message_last = 1'b1;
                end
              end
              default: begin
                stopped_next = 1'b1;
                emit         = 1'b1;
                entry.kind   = wsdf_pkg::KIND_STOP;
                entry.code   = wsdf_pkg::STOP_BAD_OPCODE;
              end
            endcase
          end
        end
        PH_PAYLOAD: begin
          pos_next = pos_inc[15:0];
          if (last) begin
            phase_next = PH_HDR0;
          end
          if (opcode == wsdf_pkg::OP_PING) begin
            emit             = 1'b1;
            entry.kind       = wsdf_pkg::KIND_PING;
            entry.raw        = rx_byte;
            entry.key        = key_sel;
            entry.frame_last = last;
          end else if (opcode != wsdf_pkg::OP_PONG) begin
            if (last && fin) begin
              msg_open_next = 1'b0;
            end
            emit               = 1'b1;
            entry.kind         = wsdf_pkg::KIND_DATA;
            entry.raw          = rx_byte;
            entry.key          = key_sel;
            entry.text         = msg_text;
            entry.frame_last   = last;
            entry.message_last = last && fin;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      fin         <= 1'b0;
      opcode      <= 4'd0;
      len_acc     <= 64'd0;
      hcount      <= 3'd0;
      mask_key    <= 32'd0;
      pos         <= 16'd0;
      msg_open    <= 1'b0;
      msg_text    <= 1'b0;
      stopped     <= 1'b0;
      max_payload <= wsdf_pkg::MAX_PAYLOAD_RESET;
    end else begin
      phase    <= phase_next;
      fin      <= fin_next;
      opcode   <= opcode_next;
      len_acc  <= len_acc_next;
      hcount   <= hcount_next;
      mask_key <= mask_key_next;
      pos      <= pos_next;
      msg_open <= msg_open_next;
      msg_text <= msg_text_next;
      stopped  <= stopped_next;
      if (cfg_write) begin
        max_payload <= cfg_data;
      end
    end
  end

endmodule

[sv/wsdf_queue.sv]
`timescale 1ns / 1ps
module wsdf_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  wsdf_pkg::entry_t wr_data,
  input  logic             rd_en,
  output wsdf_pkg::entry_t rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsdf_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/wsdf_back.sv]
`timescale 1ns / 1ps
module wsdf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  wsdf_pkg::entry_t q_data,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [2:0]       kind,
  output logic [7:0]       value,
  output logic             is_text,
  output logic             frame_last,
  output logic             message_last,
  output logic [2:0]       stop_code
);

  logic out_valid;

  assign empty = !out_valid;
  // Refill the output register when it is free or being drained.
  assign q_pop = !q_empty && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind         <= q_data.kind;
      value        <= q_data.raw ^ q_data.key;
      is_text      <= q_data.text;
      frame_last   <= q_data.frame_last;
      message_last <= q_data.message_last;
      stop_code    <= q_data.code;
    end
  end

endmodule

[sv/websocket_frame_deframer_unit.sv]
// A result is queued as its byte is taken, then moves to the output register once free.
// Throughput: one byte per cycle; the parser never waits on the output side
// until the FIFO_DEPTH-entry result queue fills, then full holds input off.
// Reset (rst, synchronous): parser returns to the first header byte, no message open,
// max_payload returns to 256, queue and output register empty.
`timescale 1ns / 1ps
module websocket_frame_deframer_unit #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [7:0]  value,
  output logic        is_text,
  output logic        frame_last,
  output logic        message_last,
  output logic [2:0]  stop_code,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  logic             accept;
  logic             emit;
  wsdf_pkg::entry_t front_entry;
  wsdf_pkg::entry_t q_data;
  logic             q_empty;
  logic             q_pop;

  assign accept = push && !full;

  wsdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .emit      (emit),
    .entry     (front_entry)
  );

  wsdf_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (emit),
    .wr_data (front_entry),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  wsdf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .kind         (kind),
    .value        (value),
    .is_text      (is_text),
    .frame_last   (frame_last),
    .message_last (message_last),
    .stop_code    (stop_code)
  );

endmodule

[sv/wsdf_checker.sv]
`timescale 1ns / 1ps
`include "websocket_frame_deframer_unit_macros.svh"
module wsdf_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  kind,
  input logic [7:0]  value,
  input logic        is_text,
  input logic        frame_last,
  input logic        message_last,
  input logic [2:0]  stop_code
);

  `WSDF_CHECK_ALWAYS(a_empty_after_reset, clk, rst |=> empty, "results left after reset")

  `WSDF_CHECK(a_hold_result, clk, rst, (!empty && !pop) |=> (!empty && $stable(kind) && $stable(value) && $stable(stop_code)), "waiting result changed")

  `WSDF_CHECK(a_stop_marks, clk, rst, (!empty && kind == wsdf_pkg::KIND_STOP) |-> (!frame_last && !message_last && !is_text && value == 8'd0), "stop result carries marks")

  `WSDF_CHECK(a_code_only_stop, clk, rst, (!empty && kind != wsdf_pkg::KIND_STOP) |-> (stop_code == 3'd0), "stop code on a non-stop result")

  `WSDF_CHECK(a_empty_kinds_end_frame, clk, rst, (!empty && (kind == wsdf_pkg::KIND_PING_EMPTY || kind == wsdf_pkg::KIND_MSG_EMPTY)) |-> (frame_last && value == 8'd0), "empty frame result without frame end")

endmodule

bind websocket_frame_deframer_unit wsdf_checker u_wsdf_checker (.*);

[tb/sv/tb_websocket_frame_deframer_unit.sv]
`timescale 1ns / 1ps
module tb_websocket_frame_deframer_unit;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_STALL = 300;
  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;
  localparam logic [2:0] NO_STOP = 3'd0;

  localparam logic [2:0] PH_FIRST  = 3'd0;
  localparam logic [2:0] PH_SECOND = 3'd1;
  localparam logic [2:0] PH_LEN16  = 3'd2;
  localparam logic [2:0] PH_LEN64  = 3'd3;
  localparam logic [2:0] PH_KEY    = 3'd4;
  localparam logic [2:0] PH_BODY   = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       is_text;
    logic       frame_last;
    logic       message_last;
    logic [2:0] stop_code;
  } ws_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       pinned;
    ws_result_t result;
  } script_row_t;

  localparam ws_result_t NO_RESULT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  value;
  logic        is_text;
  logic        frame_last;
  logic        message_last;
  logic [2:0]  stop_code;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = 16'h0000;

  // Deframer state as seen by the testbench.
  logic [2:0]  dec_phase = PH_FIRST;
  logic        dec_fin = 1'b0;
  logic [3:0]  dec_op = wsdf_pkg::OP_CONT;
  logic [63:0] dec_len = '0;
  logic [2:0]  dec_cnt = '0;
  logic [31:0] dec_key = '0;
  logic [15:0] dec_pos = '0;
  logic        dec_open = 1'b0;
  logic        dec_text = 1'b0;
  logic        dec_halted = 1'b0;
  logic [15:0] dec_limit = wsdf_pkg::MAX_PAYLOAD_RESET;

  ws_result_t pending_results[$];
  script_row_t script_rows [0:32];
  int mismatches = 0;
  int bytes_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_requests = 0;
  int stall_served = 0;
  int stall_left = 0;

  websocket_frame_deframer_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .value(value),
    .is_text(is_text),
    .frame_last(frame_last),
    .message_last(message_last),
    .stop_code(stop_code),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic ws_result_t make_result(logic [2:0] k, logic [7:0] v, logic t, logic fl,
                                             logic ml, logic [2:0] code);
    ws_result_t r;
    r.kind = k;
    r.value = v;
    r.is_text = t;
    r.frame_last = fl;
    r.message_last = ml;
    r.stop_code = code;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b, output bit produced, output ws_result_t res);
    bit halt;
    bit at_end;
    bit no_payload;
    logic [2:0] halt_code;
    logic [7:0] plain;
    produced = 1'b0;
    res = NO_RESULT;
    halt = 1'b0;
    halt_code = NO_STOP;
    if (dec_halted) return;
    case (dec_phase)
      PH_FIRST: begin
        dec_fin = b[7];
        dec_op = b[3:0];
        dec_phase = PH_SECOND;
      end
      PH_SECOND: begin
        if (!b[7]) begin
          halt = 1'b1;
          halt_code = wsdf_pkg::STOP_NO_MASK;
        end else begin
          dec_cnt = '0;
          dec_len = '0;
          dec_key = '0;
          if (b[6:0] == LEN16_CODE) begin
            dec_phase = PH_LEN16;
          end else if (b[6:0] == LEN64_CODE) begin
            dec_phase = PH_LEN64;
          end else begin
            dec_len = 64'(b[6:0]);
            if (dec_len > 64'(dec_limit)) begin
              halt = 1'b1;
              halt_code = wsdf_pkg::STOP_TOO_LARGE;
            end else begin
              dec_phase = PH_KEY;
            end
          end
        end
      end
      PH_LEN16, PH_LEN64: begin
        dec_len = {dec_len[55:0], b};
        if (32'(dec_cnt) + 1 < ((dec_phase == PH_LEN16) ? 2 : 8)) begin
          dec_cnt = dec_cnt + 3'd1;
        end else begin
          dec_cnt = '0;
          if (dec_len > 64'(dec_limit)) begin
            halt = 1'b1;
            halt_code = wsdf_pkg::STOP_TOO_LARGE;
          end else begin
            dec_phase = PH_KEY;
          end
        end
      end
      PH_KEY: begin
        dec_key = {dec_key[23:0], b};
        if (dec_cnt < 3'd3) begin
          dec_cnt = dec_cnt + 3'd1;
        end else begin
          // Header complete: opcode and fragmentation decisions happen here.
          dec_cnt = '0;
          no_payload = (dec_len == 64'd0);
          dec_pos = '0;
          dec_phase = no_payload ? PH_FIRST : PH_BODY;
          case (dec_op)
            wsdf_pkg::OP_CLOSE: begin
              halt = 1'b1;
              halt_code = wsdf_pkg::STOP_CLOSE;
            end
            wsdf_pkg::OP_PING: begin
              if (no_payload) begin
                produced = 1'b1;
                res = make_result(wsdf_pkg::KIND_PING_EMPTY, 8'h00, 1'b0, 1'b1, 1'b0,
                                  NO_STOP);
              end
            end
            wsdf_pkg::OP_PONG: ;
            wsdf_pkg::OP_TEXT, wsdf_pkg::OP_BINARY: begin
              if (dec_open) begin
                halt = 1'b1;
                halt_code = wsdf_pkg::STOP_DATA_OPEN;
              end else begin
                dec_text = (dec_op == wsdf_pkg::OP_TEXT);
                if (!no_payload) begin
                  dec_open = 1'b1;
                end else if (dec_fin) begin
                  halt = 1'b1;
                  halt_code = wsdf_pkg::STOP_EMPTY_MSG;
                end
              end
            end
            wsdf_pkg::OP_CONT: begin
              if (!dec_open) begin
                halt = 1'b1;
                halt_code = wsdf_pkg::STOP_ORPHAN_CONT;
              end else if (no_payload && dec_fin) begin
                dec_open = 1'b0;
                produced = 1'b1;
                res = make_result(wsdf_pkg::KIND_MSG_EMPTY, 8'h00, dec_text, 1'b1, 1'b1,
                                  NO_STOP);
              end
            end
            default: begin
              halt = 1'b1;
              halt_code = wsdf_pkg::STOP_BAD_OPCODE;
            end
          endcase
        end
      end
      PH_BODY: begin
        plain = b ^ dec_key[8 * (3 - dec_pos[1:0]) +: 8];
        at_end = (64'(dec_pos) + 64'd1) >= dec_len;
        dec_pos = dec_pos + 16'd1;
        if (at_end) dec_phase = PH_FIRST;
        if (dec_op == wsdf_pkg::OP_PING) begin
          produced = 1'b1;
          res = make_result(wsdf_pkg::KIND_PING, plain, 1'b0, at_end, 1'b0, NO_STOP);
        end else if (dec_op != wsdf_pkg::OP_PONG) begin
          if (at_end && dec_fin) dec_open = 1'b0;
          produced = 1'b1;
          res = make_result(wsdf_pkg::KIND_DATA, plain, dec_text, at_end, at_end && dec_fin,
                            NO_STOP);
        end
      end
      default: dec_phase = PH_FIRST;
    endcase
    if (halt) begin
      dec_halted = 1'b1;
      produced = 1'b1;
      res = make_result(wsdf_pkg::KIND_STOP, 8'h00, 1'b0, 1'b0, 1'b0, halt_code);
    end
  endtask

  // Offer one byte, hold it until the transaction completes, then predict.
  task automatic send_byte(input logic [7:0] data, input bit pinned,
                           input ws_result_t pinned_result);
    bit produced;
    ws_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= data;
    @(posedge clk);
    while (full) @(posedge clk);
    deframe_byte(data, produced, res);
    if (pinned) pending_results = {pending_results, pinned_result};
    else if (produced) pending_results = {pending_results, res};
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [3:0] op, input bit fin, input logic [63:0] len,
                            input bit with_body);
    int form;
    form = $urandom_range(5);
    if (len >= 64'd65536) form = 5;
    else if (len >= 64'd126 && form < 4) form = 4;
    send_byte({fin, 3'($urandom), op}, 1'b0, NO_RESULT);
    if (form < 4) begin
      send_byte({1'b1, len[6:0]}, 1'b0, NO_RESULT);
    end else if (form == 4) begin
      send_byte({1'b1, LEN16_CODE}, 1'b0, NO_RESULT);
      send_byte(len[15:8], 1'b0, NO_RESULT);
      send_byte(len[7:0], 1'b0, NO_RESULT);
    end else begin
      send_byte({1'b1, LEN64_CODE}, 1'b0, NO_RESULT);
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8], 1'b0, NO_RESULT);
    end
    repeat (4) send_byte(8'($urandom), 1'b0, NO_RESULT);
    if (with_body)
      for (longint i = 0; i < longint'(len); i++) send_byte(8'($urandom), 1'b0, NO_RESULT);
  endtask

  // Well-formed frame that keeps the connection alive under the current limit.
  task automatic send_random_frame();
    int top;
    int pick;
    logic [63:0] len;
    logic [3:0] op;
    bit fin;
    top = (dec_limit < 16'd40) ? int'(dec_limit) : 40;
    if ($urandom_range(15) == 0) top = (dec_limit < 16'd200) ? int'(dec_limit) : 200;
    len = 64'($urandom_range(top));
    if ($urandom_range(7) == 0) len = 64'(top);
    pick = $urandom_range(99);
    fin = 1'($urandom_range(1));
    if (pick < 15) begin
      op = wsdf_pkg::OP_PING;
    end else if (pick < 25) begin
      op = wsdf_pkg::OP_PONG;
    end else if (dec_open) begin
      op = wsdf_pkg::OP_CONT;
    end else begin
      op = $urandom_range(1) ? wsdf_pkg::OP_TEXT : wsdf_pkg::OP_BINARY;
      // an empty final data frame would stop the block
      if (len == 64'd0) fin = 1'b0;
    end
    send_frame(op, fin, len, 1'b1);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [15:0] limit);
    settle();
    cfg_write <= 1'b1;
    cfg_data <= limit;
    @(posedge clk);
    cfg_write <= 1'b0;
    dec_limit = limit;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    ws_result_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got kind %0h value %0h code %0h",
                 $time, kind, value, stop_code);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 8'(want.kind), 8'(kind));
        check_field("value", want.value, value);
        check_field("is_text", 8'(want.is_text), 8'(is_text));
        check_field("frame_last", 8'(want.frame_last), 8'(frame_last));
        check_field("message_last", 8'(want.message_last), 8'(message_last));
        check_field("stop_code", 8'(want.stop_code), 8'(stop_code));
      end
    end
  end

  // Receiver: random pops, or a long hold-off when the sender asks for one.
  always @(posedge clk) begin
    if (stall_served != stall_requests) begin
      stall_served = stall_requests;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [2:0] stop_pick;
    logic [3:0] op;
    logic [63:0] len;
    script_rows = '{
      // empty ping
      '{8'h89, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, '{wsdf_pkg::KIND_PING_EMPTY, 8'h00, 1'b0, 1'b1, 1'b0, NO_STOP}},
      // single-frame text message, one byte
      '{8'h81, 1'b0, NO_RESULT}, '{8'h81, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, '{wsdf_pkg::KIND_DATA, 8'hFF, 1'b1, 1'b1, 1'b1, NO_STOP}},
      // binary fragment without FIN, two bytes
      '{8'h02, 1'b0, NO_RESULT}, '{8'h82, 1'b0, NO_RESULT},
      '{8'h0F, 1'b0, NO_RESULT}, '{8'hF0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'hF0, 1'b1, '{wsdf_pkg::KIND_DATA, 8'hFF, 1'b0, 1'b0, 1'b0, NO_STOP}},
      '{8'h0F, 1'b1, '{wsdf_pkg::KIND_DATA, 8'hFF, 1'b0, 1'b1, 1'b0, NO_STOP}},
      // empty final continuation closes the message
      '{8'h80, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, '{wsdf_pkg::KIND_MSG_EMPTY, 8'h00, 1'b0, 1'b1, 1'b1, NO_STOP}},
      // empty pong is dropped
      '{8'h8A, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
      '{8'h12, 1'b0, NO_RESULT}, '{8'h34, 1'b0, NO_RESULT}, '{8'h56, 1'b0, NO_RESULT},
      '{8'h78, 1'b0, NO_RESULT}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 22;
    recv_idle_pct = 55;
    foreach (script_rows[i])
      send_byte(script_rows[i].data, script_rows[i].pinned, script_rows[i].result);

    set_limit(16'h0000);
    repeat (12) send_random_frame();

    set_limit(16'hFFFF);
    // hold the receiver off while a long frame keeps coming
    stall_requests++;
    send_frame(dec_open ? wsdf_pkg::OP_CONT : wsdf_pkg::OP_TEXT, 1'b1, 64'd80, 1'b1);
    while (bytes_sent < 520) send_random_frame();

    send_idle_pct = 55;
    recv_idle_pct = 22;
    set_limit(16'($urandom_range(40, 1)));
    while (bytes_sent < 950) send_random_frame();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limit(16'($urandom_range(65535, 41)));
    while (bytes_sent < 1250) send_random_frame();

    // One terminating error or close; reset is never reapplied.
    stop_pick = 3'($urandom_range(6));
    case (stop_pick)
      wsdf_pkg::STOP_CLOSE: begin
        send_frame(wsdf_pkg::OP_CLOSE, 1'($urandom_range(1)), 64'($urandom_range(8)), 1'b1);
      end
      wsdf_pkg::STOP_NO_MASK: begin
        send_byte(8'($urandom), 1'b0, NO_RESULT);
        send_byte({1'b0, 7'($urandom)}, 1'b0, NO_RESULT);
      end
      wsdf_pkg::STOP_TOO_LARGE: begin
        len = 64'(dec_limit) + 64'd1 + 64'($urandom_range(300));
        if ($urandom_range(1)) len[63:32] = $urandom;
        send_frame(4'($urandom_range(15)), 1'($urandom_range(1)), len, 1'b0);
      end
      wsdf_pkg::STOP_DATA_OPEN: begin
        if (!dec_open) send_frame(wsdf_pkg::OP_TEXT, 1'b0, 64'($urandom_range(8, 1)), 1'b1);
        send_frame($urandom_range(1) ? wsdf_pkg::OP_TEXT : wsdf_pkg::OP_BINARY,
                   1'($urandom_range(1)), 64'($urandom_range(8)), 1'b1);
      end
      wsdf_pkg::STOP_ORPHAN_CONT: begin
        if (dec_open) send_frame(wsdf_pkg::OP_CONT, 1'b1, 64'd1, 1'b1);
        send_frame(wsdf_pkg::OP_CONT, 1'($urandom_range(1)), 64'($urandom_range(8)), 1'b1);
      end
      wsdf_pkg::STOP_EMPTY_MSG: begin
        if (dec_open) send_frame(wsdf_pkg::OP_CONT, 1'b1, 64'd1, 1'b1);
        send_frame($urandom_range(1) ? wsdf_pkg::OP_TEXT : wsdf_pkg::OP_BINARY, 1'b1,
                   64'd0, 1'b1);
      end
      default: begin
        do op = 4'($urandom_range(15));
        while (op inside {wsdf_pkg::OP_CONT, wsdf_pkg::OP_TEXT, wsdf_pkg::OP_BINARY,
                          wsdf_pkg::OP_CLOSE, wsdf_pkg::OP_PING, wsdf_pkg::OP_PONG});
        send_frame(op, 1'($urandom_range(1)), 64'($urandom_range(8)), 1'b1);
      end
    endcase
    // stopped: all of this must be dropped
    repeat (40) send_byte(8'($urandom), 1'b0, NO_RESULT);

    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
